// ===== src/pva_pkg.sv =====
// ----------------------------------------------------------------------------
// Voice allocator package
// Shared payload types, controller states and control/status groups.
// ----------------------------------------------------------------------------
package pva_pkg;

   localparam int VOICE_W = 4;
   localparam int NOTE_W  = 7;
   localparam int MASK_W  = 12;

   localparam logic OP_NOTE_ON  = 1'b0;
   localparam logic OP_NOTE_OFF = 1'b1;

   typedef struct packed {
      logic              op;
      logic [NOTE_W-1:0] note;
   } req_payload_type;

   typedef struct packed {
      logic [VOICE_W-1:0] assigned_voice;
      logic               stolen;
      logic [MASK_W-1:0]  released_mask;
      logic [MASK_W-1:0]  active_mask;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_NOTE_ON,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic note_on;
      logic scan_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic in_op;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

// ===== src/pva_if.sv =====
// ----------------------------------------------------------------------------
// Voice allocator channels
// Valid/ready channels for note events and allocation results.
// ----------------------------------------------------------------------------
interface pva_req_if import pva_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pva_rsp_if import pva_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/pva_ctrl.sv =====
// ----------------------------------------------------------------------------
// Voice allocator controller
// Sequences one event: accept, note-on update or note-off voice scan, emit.
// ----------------------------------------------------------------------------
module pva_ctrl import pva_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (status.in_op == OP_NOTE_OFF) ? ST_SCAN : ST_NOTE_ON;
            end
         end
         ST_NOTE_ON: begin
            state_in = ST_EMIT;
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_NOTE_ON: begin
            cmd.note_on = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   a_load_dispatch: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_NOTE_ON || state_ff == ST_SCAN))
      else $error("accepted event did not start processing");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && status.scan_last) |=> state_ff == ST_EMIT)
      else $error("voice scan did not end at last voice");

endmodule

// ===== src/pva_datapath.sv =====
// ----------------------------------------------------------------------------
// Voice allocator datapath
// Priority list, per-voice note and on flag, scan index and result register.
// ----------------------------------------------------------------------------
module pva_datapath import pva_pkg::*; #(
   parameter int NUM_VOICES = 12
) (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output status_type      status,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int IDX_W = $clog2(NUM_VOICES);

   logic [IDX_W-1:0]      order_ff [NUM_VOICES];
   logic [NOTE_W-1:0]     note_ff  [NUM_VOICES];
   logic [NUM_VOICES-1:0] on_ff;
   logic [NOTE_W-1:0]     item_note_ff;
   logic [IDX_W-1:0]      scan_ff;
   logic [IDX_W-1:0]      assigned_ff;
   logic                  stolen_ff;
   logic [NUM_VOICES-1:0] released_ff;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_payload_ff;

   logic [IDX_W-1:0]      head;
   logic                  scan_match;
   logic [NUM_VOICES-1:0] hit;
   logic [NUM_VOICES-1:0] found_ge;

   assign head       = order_ff[0];
   assign scan_match = (note_ff[scan_ff] == item_note_ff);

   // entries at or in front of the scanned voice shift back by one
   always_comb begin
      for (int i = 0; i < NUM_VOICES; i++) begin
         hit[i] = (order_ff[i] == scan_ff);
      end
      for (int i = 0; i < NUM_VOICES; i++) begin
         found_ge[i] = |(hit >> i);
      end
   end

   assign status.in_op     = req_payload.op;
   assign status.scan_last = (scan_ff == IDX_W'(NUM_VOICES - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VOICES; i++) begin
            order_ff[i] <= IDX_W'(i);
            note_ff[i]  <= '0;
         end
         on_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            item_note_ff <= req_payload.note;
            scan_ff      <= '0;
            assigned_ff  <= '0;
            stolen_ff    <= 1'b0;
            released_ff  <= '0;
         end
         if (cmd.note_on) begin
            for (int i = 0; i < NUM_VOICES - 1; i++) begin
               order_ff[i] <= order_ff[i+1];
            end
            order_ff[NUM_VOICES-1] <= head;
            assigned_ff            <= head;
            stolen_ff              <= on_ff[head];
            note_ff[head]          <= item_note_ff;
            on_ff[head]            <= 1'b1;
         end
         if (cmd.scan_step) begin
            scan_ff <= scan_ff + 1'b1;
            if (scan_match) begin
               on_ff[scan_ff]       <= 1'b0;
               released_ff[scan_ff] <= 1'b1;
               order_ff[0]          <= scan_ff;
               for (int i = 1; i < NUM_VOICES; i++) begin
                  if (found_ge[i]) begin
                     order_ff[i] <= order_ff[i-1];
                  end
               end
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff                  <= 1'b1;
            rsp_payload_ff.assigned_voice <= VOICE_W'(assigned_ff);
            rsp_payload_ff.stolen         <= stolen_ff;
            rsp_payload_ff.released_mask  <= MASK_W'(released_ff);
            rsp_payload_ff.active_mask    <= MASK_W'(on_ff);
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_head_to_tail: assert property (@(posedge clock) disable iff (reset)
      cmd.note_on |=> order_ff[NUM_VOICES-1] == $past(order_ff[0]))
      else $error("note-on did not rotate head to tail");

   a_voice_on: assert property (@(posedge clock) disable iff (reset)
      cmd.note_on |=> on_ff[$past(order_ff[0])])
      else $error("note-on did not set voice on");

   a_release_head: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && scan_match) |=> order_ff[0] == $past(scan_ff))
      else $error("released voice not moved to head");

   a_voice_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> 32'(rsp_payload_ff.assigned_voice) < NUM_VOICES)
      else $error("assigned voice out of range");

endmodule

// ===== src/polyphonic_voice_allocator.sv =====
// ----------------------------------------------------------------------------
// Polyphonic voice allocator
// Least-recently-used voice allocation for note-on and note-off events.
//
//   channel   dir   payload                                          handshake
//   req_ch    in    op, note                                         valid/ready
//   rsp_ch    out   assigned_voice, stolen, released_mask, active_mask valid/ready
//
// Note-on goes from transfer through the note-on step to the result; note-off first runs
// the voice scan, which visits one voice per cycle, over all NUM_VOICES voices.
// One event is in process at a time; the next transfer is taken once the
// result is loaded into the output register, even if that result still waits.
// Synchronous reset restores the identity priority order and clears all voices.
// A stalled result holds the output register and the controller in its emit step.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator import pva_pkg::*; #(
   parameter int NUM_VOICES = 12
) (
   input logic       clock,
   input logic       reset,
   pva_req_if.sink   req_ch,
   pva_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   pva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pva_datapath #(
      .NUM_VOICES (NUM_VOICES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_ch.payload),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_payload (rsp_ch.payload)
   );

endmodule
